FILE: sv/bitmap_page_allocator_defines.svh
// Assertion shorthands used by the allocator controller.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on clk with arst_n as the disable.
`define BPA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BPA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

	localparam int WORD_BITS = 64;
	localparam int WORD_LOG2 = 6;
	localparam int CNT_W     = 13;
	localparam logic [CNT_W-1:0] CNT_MAX = 13'h1FFF;

	localparam int RST_PAGE_LIMIT = 4096;
	localparam int RST_RESERVED   = 768;

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_INIT  = 2'd2;

	localparam logic [1:0] RSP_OK    = 2'd0;
	localparam logic [1:0] RSP_NOFIT = 2'd1;
	localparam logic [1:0] RSP_BAD   = 2'd2;

	localparam logic REG_PAGE_LIMIT = 1'b0;
	localparam logic REG_RESERVED   = 1'b1;

	typedef enum logic [3:0] {
		S_RST_SWEEP,
		S_IDLE,
		S_DECODE,
		S_SWEEP,
		S_SCAN_RD,
		S_SCAN_EV,
		S_PASS2,
		S_TAKE,
		S_FREE_RD,
		S_FREE_EV,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		JOB_DONE,
		JOB_SWEEP,
		JOB_SCAN,
		JOB_PASS2,
		JOB_FREE
	} job_t;

	typedef struct packed {
		logic capture;
		logic decode;
		logic sweep;
		logic rd;
		logic scan_ev;
		logic pass2;
		logic take;
		logic free_ev;
		logic finish;
	} cmd_t;

	typedef struct packed {
		job_t job;
		logic last;
		logic found;
		logic pass2_ok;
	} sts_t;

endpackage

FILE: sv/bpa_ctrl.sv
`timescale 1ns / 1ps
`include "bitmap_page_allocator_defines.svh"

module bpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  bpa_pkg::sts_t sts,
	output bpa_pkg::cmd_t cmd
);
	import bpa_pkg::*;

	state_t state_q, state_nx;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RST_SWEEP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_RST_SWEEP: begin
				if (sts.last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_nx = S_DECODE;
			end
			S_DECODE: begin
				case (sts.job)
					JOB_SWEEP: state_nx = S_SWEEP;
					JOB_SCAN:  state_nx = S_SCAN_RD;
					JOB_PASS2: state_nx = S_PASS2;
					JOB_FREE:  state_nx = S_FREE_RD;
					default:   state_nx = S_DONE;
				endcase
			end
			S_SWEEP: begin
				if (sts.last) state_nx = S_DONE;
			end
			S_SCAN_RD: state_nx = S_SCAN_EV;
			S_SCAN_EV: begin
				if (sts.found) state_nx = S_TAKE;
				else if (sts.last) state_nx = S_PASS2;
				else state_nx = S_SCAN_RD;
			end
			S_PASS2: begin
				state_nx = sts.pass2_ok ? S_SCAN_RD : S_DONE;
			end
			S_TAKE: begin
				if (sts.last) state_nx = S_DONE;
			end
			S_FREE_RD: state_nx = S_FREE_EV;
			S_FREE_EV: begin
				state_nx = sts.last ? S_DONE : S_FREE_RD;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_RST_SWEEP: cmd.sweep   = 1'b1;
			S_IDLE:      cmd.capture = in_valid;
			S_DECODE:    cmd.decode  = 1'b1;
			S_SWEEP:     cmd.sweep   = 1'b1;
			S_SCAN_RD:   cmd.rd      = 1'b1;
			S_SCAN_EV:   cmd.scan_ev = 1'b1;
			S_PASS2:     cmd.pass2   = 1'b1;
			S_TAKE:      cmd.take    = 1'b1;
			S_FREE_RD:   cmd.rd      = 1'b1;
			S_FREE_EV:   cmd.free_ev = 1'b1;
			S_DONE:      cmd.finish  = !out_valid_q || !out_stall;
			default:     cmd = '0;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	`BPA_ASSERT_NXT(a_accept_decodes, in_valid && !in_stall, state_q == S_DECODE, "accepted beat not decoded")
	`BPA_ASSERT_IMP(a_scan_ev_after_rd, state_q == S_SCAN_EV, $past(state_q) == S_SCAN_RD, "scan evaluated without a read")
	`BPA_ASSERT_IMP(a_free_ev_after_rd, state_q == S_FREE_EV, $past(state_q) == S_FREE_RD, "free evaluated without a read")
	`BPA_ASSERT_IMP(a_result_from_done, $rose(out_valid_q), $past(state_q) == S_DONE, "result raised outside completion")

endmodule

FILE: sv/bpa_dp.sv
`timescale 1ns / 1ps

module bpa_dp #(
	parameter int NUM_PAGES       = 4096,
	parameter int PAGE_BYTES_LOG2 = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [bpa_pkg::CNT_W-1:0]   cfg_data,
	input  logic [1:0]                  mode,
	input  logic [bpa_pkg::CNT_W-1:0]   req_pages,
	input  logic [31:0]                 phys_address,
	input  bpa_pkg::cmd_t               cmd,
	output bpa_pkg::sts_t               sts,
	output logic [1:0]                  status,
	output logic [31:0]                 page_address,
	output logic [bpa_pkg::CNT_W-1:0]   pages_changed,
	output logic [bpa_pkg::CNT_W-1:0]   free_count,
	output logic [bpa_pkg::CNT_W-1:0]   used_count
);
	import bpa_pkg::*;

	localparam int NWORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int PIW     = (AW + WORD_LOG2 + 1 > 14) ? AW + WORD_LOG2 + 1 : 14;
	localparam int AMW     = 32 - PAGE_BYTES_LOG2;
	localparam int FW      = ((AMW > CNT_W) ? AMW : CNT_W) + 1;
	localparam int RST_LIM = (NUM_PAGES < RST_PAGE_LIMIT) ? NUM_PAGES : RST_PAGE_LIMIT;
	localparam int RST_RES = (RST_LIM < RST_RESERVED) ? RST_LIM : RST_RESERVED;
	localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

	// lowest set bit, 64 when none
	function automatic logic [6:0] low_set(input logic [63:0] v);
		logic [7:0] nz;
		logic [2:0] bi;
		logic [2:0] wi;
		logic [7:0] byt;
		for (int b = 0; b < 8; b++) nz[b] = |v[8*b +: 8];
		bi = '0;
		for (int b = 7; b >= 0; b--) if (nz[b]) bi = 3'(b);
		byt = v[{bi, 3'b000} +: 8];
		wi = '0;
		for (int j = 7; j >= 0; j--) if (byt[j]) wi = 3'(j);
		return (|nz) ? {1'b0, bi, wi} : 7'd64;
	endfunction

	function automatic logic [63:0] rev64(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[i] = v[63-i];
		return r;
	endfunction

	function automatic logic [6:0] pop64(input logic [63:0] v);
		logic [3:0] bc [8];
		logic [6:0] s;
		for (int b = 0; b < 8; b++) begin
			bc[b] = '0;
			for (int j = 0; j < 8; j++) bc[b] = bc[b] + 4'(v[8*b+j]);
		end
		s = '0;
		for (int b = 0; b < 8; b++) s = s + 7'(bc[b]);
		return s;
	endfunction

	// bit i set where n free bits start at i inside the word
	function automatic logic [63:0] run_starts(input logic [63:0] v, input logic [6:0] n);
		logic [63:0] acc;
		logic [63:0] pw;
		logic [6:0]  sh;
		acc = '1;
		pw  = v;
		sh  = '0;
		for (int b = 0; b < 7; b++) begin
			if (n[b]) begin
				acc = acc & (pw >> sh);
				sh  = sh + 7'(1 << b);
			end
			pw = pw & (pw >> (1 << b));
		end
		return acc;
	endfunction

	logic [63:0] map_mem [NWORDS];
	logic [63:0] rdata_q;

	logic [CNT_W-1:0] page_limit_q, reserved_q;
	logic [1:0]       mode_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      addr_q;
	logic [CNT_W-1:0] hint_q, free_q, used_q, lim_q, res_q;
	logic [CNT_W-1:0] lo_q, hi_q, run_q, run_start_q;
	logic [AW-1:0]    ptr_q, end_q;
	logic             single_q, pass2_q;
	logic [1:0]       status_q;
	logic [31:0]      raddr_q;
	logic [CNT_W-1:0] changed_q;

	logic [CNT_W-1:0] eff_lim, res_c, p2_hi, base13, fend;
	logic [FW-1:0]    base_ext, fend_raw;
	logic             base_ok, misaligned, hint_lt;
	logic [PIW-1:0]   wbase;
	logic [63:0]      inr, sw, fmap, runs, fr;
	logic [6:0]       tz, lf, wpos, pc, lowi;
	logic             win, carry_hit, found, all_free;
	logic [13:0]      sum14, tsum, used_sum, free_sum;
	logic [PIW-1:0]   wpos_pg, lf_pg, low_pg;
	logic [CNT_W-1:0] fstart, thi, run_nx, run_start_nx;
	logic [44:0]      addr_wide;
	logic [CNT_W-1:0] take_free, take_used, rel_free, rel_used;
	job_t             dec_job;
	logic [1:0]       dec_status;
	logic             we;
	logic [63:0]      wmask, wdata;

	assign eff_lim = (PIW'(page_limit_q) < PIW'(NUM_PAGES)) ? page_limit_q : CNT_W'(NUM_PAGES);
	assign res_c   = (reserved_q < eff_lim) ? reserved_q : eff_lim;
	assign hint_lt = hint_q < eff_lim;
	assign p2_hi   = hint_lt ? hint_q : eff_lim;

	assign misaligned = |addr_q[PAGE_BYTES_LOG2-1:0];
	assign base_ext   = FW'(addr_q[31:PAGE_BYTES_LOG2]);
	assign base_ok    = base_ext < FW'(eff_lim);
	assign base13     = base_ext[CNT_W-1:0];
	assign fend_raw   = base_ext + FW'(cnt_q);
	assign fend       = (fend_raw < FW'(eff_lim)) ? fend_raw[CNT_W-1:0] : eff_lim;

	assign wbase = PIW'(ptr_q) << WORD_LOG2;

	always_comb begin
		logic [PIW-1:0] pg;
		for (int i = 0; i < WORD_BITS; i++) begin
			pg     = wbase + PIW'(i);
			inr[i] = (pg >= PIW'(lo_q)) && (pg < PIW'(hi_q));
			sw[i]  = (pg < PIW'(res_q)) || (pg >= PIW'(lim_q));
		end
	end

	// run search over one word, with the run carried in from the words below
	assign fmap      = inr & ~rdata_q;
	assign tz        = low_set(~fmap);
	assign lf        = low_set(~rev64(fmap));
	assign runs      = run_starts(fmap, cnt_q[6:0]);
	assign wpos      = low_set(runs);
	assign win       = (cnt_q <= CNT_W'(WORD_BITS)) && (runs != '0);
	assign sum14     = 14'(run_q) + 14'(tz);
	assign carry_hit = (run_q != '0) && (sum14 >= 14'(cnt_q));
	assign found     = carry_hit || win;
	assign wpos_pg   = wbase + PIW'(wpos[5:0]);
	assign fstart    = carry_hit ? run_start_q : wpos_pg[CNT_W-1:0];
	assign thi       = fstart + cnt_q;
	assign all_free  = tz[6];
	assign lf_pg     = wbase + PIW'(WORD_BITS) - PIW'(lf);
	assign run_nx    = all_free ? run_q + CNT_W'(WORD_BITS) : CNT_W'(lf);
	assign run_start_nx = all_free ? ((run_q == '0) ? wbase[CNT_W-1:0] : run_start_q)
	                               : lf_pg[CNT_W-1:0];
	assign addr_wide = 45'(fstart) << PAGE_BYTES_LOG2;

	assign take_free = (free_q >= cnt_q) ? free_q - cnt_q : '0;
	assign used_sum  = 14'(used_q) + 14'(cnt_q);
	assign take_used = (used_sum > 14'(CNT_MAX)) ? CNT_MAX : used_sum[CNT_W-1:0];

	// release: clear used pages that lie in range
	assign fr       = rdata_q & inr;
	assign pc       = pop64(fr);
	assign lowi     = low_set(fr);
	assign low_pg   = wbase + PIW'(lowi[5:0]);
	assign free_sum = 14'(free_q) + 14'(pc);
	assign rel_free = (free_sum > 14'(CNT_MAX)) ? CNT_MAX : free_sum[CNT_W-1:0];
	assign rel_used = (used_q >= CNT_W'(pc)) ? used_q - CNT_W'(pc) : '0;
	assign tsum     = 14'(changed_q) + 14'(pc);

	always_comb begin
		dec_job    = JOB_DONE;
		dec_status = RSP_BAD;
		case (mode_q)
			MODE_INIT: begin
				dec_job    = JOB_SWEEP;
				dec_status = RSP_OK;
			end
			MODE_ALLOC: begin
				if (cnt_q != '0) begin
					dec_status = RSP_NOFIT;
					if (cnt_q <= eff_lim) begin
						if (hint_lt) dec_job = JOB_SCAN;
						else if (cnt_q == CNT_W'(1)) dec_job = JOB_PASS2;
					end
				end
			end
			MODE_FREE: begin
				if (!misaligned) begin
					dec_status = RSP_OK;
					if (cnt_q != '0 && base_ok) dec_job = JOB_FREE;
				end
			end
			default: dec_job = JOB_DONE;
		endcase
	end

	assign sts.job      = dec_job;
	assign sts.last     = (ptr_q == end_q);
	assign sts.found    = found;
	assign sts.pass2_ok = single_q && !pass2_q && (p2_hi != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_limit_q <= CNT_W'(RST_PAGE_LIMIT);
			reserved_q   <= CNT_W'(RST_RESERVED);
			hint_q       <= CNT_W'(RST_RES);
			free_q       <= CNT_W'(RST_LIM - RST_RES);
			used_q       <= CNT_W'(RST_RES);
			lim_q        <= CNT_W'(RST_LIM);
			res_q        <= CNT_W'(RST_RES);
			lo_q         <= '0;
			hi_q         <= '0;
			run_q        <= '0;
			run_start_q  <= '0;
			ptr_q        <= '0;
			end_q        <= LAST_WORD;
			single_q     <= 1'b0;
			pass2_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_PAGE_LIMIT) page_limit_q <= cfg_data;
				else reserved_q <= cfg_data;
			end
			if (cmd.decode) begin
				single_q <= (cnt_q == CNT_W'(1));
				pass2_q  <= 1'b0;
				run_q    <= '0;
				case (dec_job)
					JOB_SWEEP: begin
						lim_q  <= eff_lim;
						res_q  <= res_c;
						hint_q <= res_c;
						free_q <= eff_lim - res_c;
						used_q <= res_c;
						ptr_q  <= '0;
						end_q  <= LAST_WORD;
					end
					JOB_SCAN: begin
						lo_q  <= hint_q;
						hi_q  <= eff_lim;
						ptr_q <= AW'(hint_q >> WORD_LOG2);
						end_q <= AW'((eff_lim - CNT_W'(1)) >> WORD_LOG2);
					end
					JOB_FREE: begin
						lo_q  <= base13;
						hi_q  <= fend;
						ptr_q <= AW'(base13 >> WORD_LOG2);
						end_q <= AW'((fend - CNT_W'(1)) >> WORD_LOG2);
					end
					default: begin
						lo_q <= lo_q;
					end
				endcase
			end
			if (cmd.sweep && !sts.last) ptr_q <= ptr_q + AW'(1);
			if (cmd.pass2 && sts.pass2_ok) begin
				pass2_q <= 1'b1;
				run_q   <= '0;
				lo_q    <= '0;
				hi_q    <= p2_hi;
				ptr_q   <= '0;
				end_q   <= AW'((p2_hi - CNT_W'(1)) >> WORD_LOG2);
			end
			if (cmd.scan_ev) begin
				if (found) begin
					if (single_q) hint_q <= fstart;
					free_q <= take_free;
					used_q <= take_used;
					lo_q   <= fstart;
					hi_q   <= thi;
					ptr_q  <= AW'(fstart >> WORD_LOG2);
					end_q  <= AW'((thi - CNT_W'(1)) >> WORD_LOG2);
				end else begin
					run_q       <= run_nx;
					run_start_q <= run_start_nx;
					if (!sts.last) ptr_q <= ptr_q + AW'(1);
				end
			end
			if (cmd.take && !sts.last) ptr_q <= ptr_q + AW'(1);
			if (cmd.free_ev) begin
				free_q <= rel_free;
				used_q <= rel_used;
				if ((fr != '0) && (low_pg < PIW'(hint_q))) hint_q <= low_pg[CNT_W-1:0];
				if (!sts.last) ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			cnt_q  <= req_pages;
			addr_q <= phys_address;
		end
		if (cmd.decode) begin
			status_q  <= dec_status;
			raddr_q   <= '0;
			changed_q <= '0;
		end
		if (cmd.scan_ev && found) begin
			status_q  <= RSP_OK;
			raddr_q   <= addr_wide[31:0];
			changed_q <= cnt_q;
		end
		if (cmd.free_ev) changed_q <= tsum[CNT_W-1:0];
		if (cmd.finish) begin
			status        <= status_q;
			page_address  <= raddr_q;
			pages_changed <= changed_q;
			free_count    <= free_q;
			used_count    <= used_q;
		end
	end

	// bit-enabled word write; read data registered
	assign we    = cmd.sweep | cmd.take | cmd.free_ev;
	assign wmask = cmd.sweep ? '1 : (cmd.take ? inr : fr);
	assign wdata = cmd.sweep ? sw : (cmd.take ? '1 : '0);

	always_ff @(posedge clk) begin
		if (we) begin
			for (int i = 0; i < WORD_BITS; i++)
				if (wmask[i]) map_mem[ptr_q][i] <= wdata[i];
		end
		if (cmd.rd) rdata_q <= map_mem[ptr_q];
	end

endmodule

FILE: sv/bitmap_page_allocator.sv
// Page allocator over a used-page bitmap held in a 64-bit-wide memory, with a
// next-fit hint and free/used counters. Each item returns one result.
// Initialize writes the map at one word a cycle; allocate reads each 64-page
// word it searches from memory, then evaluates it, and then marks the found
// words used; free reads, then clears, each word in the released range; each
// item also passes through decode and hand-off. After reset the block writes
// the initial map and holds in_stall high meanwhile. A finished result sits in
// an output register, so the next item is taken while it waits.
`timescale 1ns / 1ps

module bitmap_page_allocator #(
	parameter int NUM_PAGES       = 4096,
	parameter int PAGE_BYTES_LOG2 = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [bpa_pkg::CNT_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                mode,
	input  logic [bpa_pkg::CNT_W-1:0] req_pages,
	input  logic [31:0]               phys_address,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [31:0]               page_address,
	output logic [bpa_pkg::CNT_W-1:0] pages_changed,
	output logic [bpa_pkg::CNT_W-1:0] free_count,
	output logic [bpa_pkg::CNT_W-1:0] used_count
);
	import bpa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bpa_dp #(
		.NUM_PAGES      (NUM_PAGES),
		.PAGE_BYTES_LOG2(PAGE_BYTES_LOG2)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.req_pages    (req_pages),
		.phys_address (phys_address),
		.cmd          (cmd),
		.sts          (sts),
		.status       (status),
		.page_address (page_address),
		.pages_changed(pages_changed),
		.free_count   (free_count),
		.used_count   (used_count)
	);

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import bpa_pkg::*;

	typedef struct {
		logic [1:0]  mode;
		logic [12:0] count;
		logic [31:0] addr;
	} req_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] addr;
		logic [12:0] changed;
		logic [12:0] free_n;
		logic [12:0] used_n;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [12:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = MODE_INIT;
	logic [12:0] req_pages = '0;
	logic [31:0] phys_address = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [31:0] page_address;
	logic [12:0] pages_changed, free_count, used_count;

	bitmap_page_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .req_pages(req_pages), .phys_address(phys_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .page_address(page_address), .pages_changed(pages_changed),
		.free_count(free_count), .used_count(used_count)
	);

	// allocator shadow state
	bit          page_used [4096];
	int unsigned hint, free_tot, used_tot, lim_reg, res_reg;

	req_t req_q[$];
	rsp_t pending_results[$];
	int   errors = 0;
	bit   quiet = 1'b0;
	int   cur_lim = 4096;
	int   in_gap = 0;
	int   out_gap = 0;

	initial forever #2 clk = ~clk;

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic int unsigned eff_lim();
		return (lim_reg < 4096) ? lim_reg : 4096;
	endfunction

	function automatic bit is_taken(int unsigned pg);
		if (pg >= eff_lim())
			return 1'b1;
		return page_used[pg];
	endfunction

	function automatic void rebuild_map();
		int unsigned l, r;
		l = eff_lim();
		r = (res_reg < l) ? res_reg : l;
		for (int p = 0; p < 4096; p++)
			page_used[p] = (p < r) || (p >= l);
		hint = r;
		free_tot = l - r;
		used_tot = r;
	endfunction

	function automatic void claim(int unsigned start, int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			if (start + i < 4096)
				page_used[start + i] = 1'b1;
		free_tot = (free_tot >= n) ? free_tot - n : 0;
		used_tot = (used_tot + n > 8191) ? 8191 : used_tot + n;
	endfunction

	function automatic rsp_t alloc_predict(req_t r);
		rsp_t o;
		int unsigned l, found, run, cnt;
		bit ok;
		longint unsigned base, idx;
		l = eff_lim();
		cnt = 32'(r.count);
		ok = 1'b0;
		found = 0;
		o.status = RSP_OK;
		o.addr = '0;
		o.changed = '0;
		if (r.mode == MODE_INIT) begin
			rebuild_map();
		end else if (r.mode == MODE_ALLOC) begin
			if (cnt == 0) begin
				o.status = RSP_BAD;
			end else if (cnt == 1) begin
				for (int unsigned p = hint; p < l && !ok; p++)
					if (!is_taken(p)) begin found = p; ok = 1'b1; end
				for (int unsigned p = 0; p < hint && p < l && !ok; p++)
					if (!is_taken(p)) begin found = p; ok = 1'b1; end
				if (ok) begin
					hint = found;
					claim(found, 1);
					o.addr = found << 12;
					o.changed = 13'(1);
				end else
					o.status = RSP_NOFIT;
			end else begin
				// lowest free run at or above the hint, no wrap
				run = 0;
				if (cnt <= l)
					for (int unsigned p = hint; p < l && !ok; p++) begin
						run = is_taken(p) ? 0 : run + 1;
						if (run == cnt) begin found = p - cnt + 1; ok = 1'b1; end
					end
				if (ok) begin
					claim(found, cnt);
					o.addr = found << 12;
					o.changed = 13'(cnt);
				end else
					o.status = RSP_NOFIT;
			end
		end else if (r.mode == MODE_FREE) begin
			if (r.addr[11:0] != 0) begin
				o.status = RSP_BAD;
			end else begin
				base = 64'(r.addr >> 12);
				for (int unsigned i = 0; i < cnt; i++) begin
					idx = base + 64'(i);
					if (idx < l && is_taken(32'(idx))) begin
						page_used[idx] = 1'b0;
						free_tot = (free_tot < 8191) ? free_tot + 1 : 8191;
						used_tot = (used_tot > 0) ? used_tot - 1 : 0;
						if (idx < hint)
							hint = 32'(idx);
						o.changed = o.changed + 13'(1);
					end
				end
			end
		end else begin
			o.status = RSP_BAD;
		end
		o.free_n = 13'(free_tot);
		o.used_n = 13'(used_tot);
		return o;
	endfunction

	function automatic int pick_gap();
		if (quiet)
			return 0;
		if ($urandom_range(0, 9) < 6)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		req_t it;
		rsp_t e;
		bit busy;
		bit v;
		if (arst_n) begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				it.mode = mode;
				it.count = req_pages;
				it.addr = phys_address;
				e = alloc_predict(it);
				pending_results.push_back(e);
				busy = 1'b0;
			end
			if (!busy) begin
				v = 1'b0;
				if (in_gap > 0) begin
					in_gap--;
				end else if (req_q.size() > 0) begin
					it = req_q.pop_front();
					mode <= it.mode;
					req_pages <= it.count;
					phys_address <= it.addr;
					v = 1'b1;
					in_gap = pick_gap();
				end
				in_valid <= v;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected beat", 0, 0);
				end else begin
					e = pending_results.pop_front();
					if (status !== e.status) report_mismatch("status", status, e.status);
					if (page_address !== e.addr)
						report_mismatch("page_address", page_address, e.addr);
					if (pages_changed !== e.changed)
						report_mismatch("pages_changed", pages_changed, e.changed);
					if (free_count !== e.free_n)
						report_mismatch("free_count", free_count, e.free_n);
					if (used_count !== e.used_n)
						report_mismatch("used_count", used_count, e.used_n);
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_gap = pick_gap();
				out_stall <= (out_gap > 0);
			end else
				out_stall <= 1'b0;
		end
	end

	task automatic push(logic [1:0] m, int unsigned c, logic [31:0] a);
		req_t r;
		r.mode = m;
		r.count = 13'(c);
		r.addr = a;
		req_q.push_back(r);
	endtask

	task automatic drain();
		wait (req_q.size() == 0 && !in_valid && pending_results.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 13'(val);
		if (idx == REG_PAGE_LIMIT) begin
			lim_reg = val;
			cur_lim = (val < 4096) ? val : 4096;
		end else
			res_reg = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_phase(int unsigned lim, int unsigned res, bit do_init);
		drain();
		write_reg(REG_PAGE_LIMIT, lim);
		write_reg(REG_RESERVED, res);
		if (do_init)
			push(MODE_INIT, $urandom_range(0, 8191), $urandom);
	endtask

	task automatic random_items(int n);
		int r;
		int unsigned pg;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				if ($urandom_range(0, 9) < 7)
					push(MODE_ALLOC, 1, $urandom);
				else if ($urandom_range(0, 9) < 9)
					push(MODE_ALLOC, $urandom_range(2, 16), $urandom);
				else
					push(MODE_ALLOC, $urandom_range(1, 4096), $urandom);
			end else if (r < 80) begin
				pg = $urandom_range(0, cur_lim);
				push(MODE_FREE, ($urandom_range(0, 9) < 9) ? $urandom_range(0, 16)
					: $urandom_range(0, 4096), pg << 12);
			end else if (r < 84) begin
				push(MODE_INIT, $urandom_range(0, 8191), $urandom);
			end else if (r < 89) begin
				push(MODE_FREE, $urandom_range(0, 16), $urandom | $urandom_range(1, 4095));
			end else if (r < 92) begin
				push(2'd3, $urandom_range(0, 8191), $urandom);
			end else if (r < 95) begin
				push(MODE_ALLOC, 0, $urandom);
			end else begin
				push(2'($urandom_range(0, 3)), $urandom_range(0, 4096),
					$urandom & 32'hFFFF_F000);
			end
		end
	endtask

	initial begin
		lim_reg = RST_PAGE_LIMIT;
		res_reg = RST_RESERVED;
		rebuild_map();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// hold off while the initial map is written after reset
		wait (!in_stall);

		// directed: full map, reset-like setting
		quiet = 1'b1;
		set_phase(4096, 768, 1'b1);
		push(MODE_ALLOC, 0, 0);
		push(MODE_ALLOC, 1, 0);
		push(MODE_ALLOC, 4096, 0);
		push(MODE_ALLOC, 3, 0);
		push(MODE_FREE, 1, 32'h0000_0FFF);
		push(MODE_FREE, 0, 32'h0000_0000);
		push(MODE_FREE, 1, 32'h0000_0000);
		push(MODE_FREE, 4, 32'hFFFF_F000);
		push(2'd3, 13'h1FFF, 32'hFFFF_FFFF);
		push(MODE_FREE, 4096, 32'h0000_0000);
		push(MODE_ALLOC, 4096, 0);
		push(MODE_ALLOC, 1, 0);
		push(MODE_FREE, 2, 32'h0000_5000);
		push(MODE_ALLOC, 1, 0);
		push(MODE_ALLOC, 1, 0);
		// reserved above the limit, count above the limit
		set_phase(100, 4096, 1'b1);
		push(MODE_ALLOC, 1, 0);
		push(MODE_ALLOC, 101, 0);
		push(MODE_FREE, 8, 32'h0005_C000);
		push(MODE_ALLOC, 4, 0);
		// smallest map
		set_phase(1, 0, 1'b1);
		push(MODE_ALLOC, 1, 0);
		push(MODE_ALLOC, 1, 0);
		push(MODE_FREE, 2, 0);
		quiet = 1'b0;

		set_phase(4096, 768, 1'b1);
		random_items(200);
		set_phase(64, 8, 1'b1);
		random_items(80);
		set_phase(4096, 0, 1'b1);
		quiet = 1'b1;
		random_items(60);
		drain();
		quiet = 1'b0;
		random_items(60);
		set_phase(300, 4096, 1'b1);
		random_items(40);
		// limit moves without a fresh map: counters drift
		set_phase(1000, 20, 1'b0);
		random_items(60);
		set_phase(4096, 4096, 1'b1);
		random_items(40);
		set_phase(1, 0, 1'b1);
		random_items(30);
		set_phase(513, 1, 1'b1);
		random_items(40);

		drain();
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
